// File: src/ptd_pkg.sv
`default_nettype none

package ptd_pkg;

    localparam int VALUE_BITS_DEF = 31;
    localparam int unsigned LIMIT_RESET = 32'd10000000;
    localparam int unsigned FIRST_DIVISOR = 32'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAND,
        S_CHECK,
        S_DIV,
        S_DONE
    } ctr_state_t;

    typedef struct packed {
        logic start;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } div_rsp_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ctr_stat_t;

endpackage

`default_nettype wire

// File: src/ptd_divider.sv
`default_nettype none

module ptd_divider #(
    parameter int VALUE_BITS = ptd_pkg::VALUE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ptd_pkg::div_req_t     req,
    input  wire logic [VALUE_BITS-1:0] dividend,
    input  wire logic [VALUE_BITS-1:0] divisor,
    output ptd_pkg::div_rsp_t          rsp
);
    import ptd_pkg::*;

    localparam int CW = $clog2(VALUE_BITS);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [VALUE_BITS-1:0] r_reg, r_next;
    logic [VALUE_BITS-1:0] d_reg, d_next;

    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   diff;
    logic [VALUE_BITS-1:0] r_step;

    // One restoring step: the next dividend bit enters the partial remainder.
    always_comb
    begin
        trial  = {r_reg, q_reg[VALUE_BITS-1]};
        diff   = trial - {1'b0, d_reg};
        r_step = diff[VALUE_BITS] ? trial[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(VALUE_BITS - 1);
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[VALUE_BITS-2:0], 1'b0};
            r_next = r_step;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.rem_zero = (r_reg == '0);

endmodule

`default_nettype wire

// File: src/ptd_counter.sv
`default_nettype none

module ptd_counter #(
    parameter int VALUE_BITS = ptd_pkg::VALUE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  ack,
    input  wire logic [VALUE_BITS-1:0] limit,
    output ptd_pkg::ctr_stat_t         stat,
    output logic [VALUE_BITS-1:0]      result
);
    import ptd_pkg::*;

    localparam int SQ_W = VALUE_BITS + 2;

    ctr_state_t            state_reg, state_next;
    logic [VALUE_BITS-1:0] cand_reg, cand_next;
    logic [VALUE_BITS-1:0] div_reg, div_next;
    logic [SQ_W-1:0]       sq_reg, sq_next;
    logic [VALUE_BITS-1:0] cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] lim_reg, lim_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic sq_over;
    logic cand_small;

    assign sq_over    = sq_reg > {2'b00, cand_reg};
    assign cand_small = cand_reg < VALUE_BITS'(FIRST_DIVISOR);

    ptd_divider #(
        .VALUE_BITS(VALUE_BITS)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .dividend(cand_reg),
        .divisor (div_reg),
        .rsp     (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_CAND;
            end
            S_CAND:
            begin
                if (cand_reg == lim_reg)
                    state_next = S_DONE;
                else if (!cand_small)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = sq_over ? S_CAND : S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                    state_next = div_rsp.rem_zero ? S_CAND : S_CHECK;
            end
            S_DONE:
            begin
                if (ack)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cand_next     = cand_reg;
        div_next      = div_reg;
        sq_next       = sq_reg;
        cnt_next      = cnt_reg;
        lim_next      = lim_reg;
        div_req.start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cand_next = '0;
                    cnt_next  = '0;
                    lim_next  = limit;
                end
            end
            S_CAND:
            begin
                if (cand_reg != lim_reg)
                begin
                    if (cand_small)
                    begin
                        cand_next = cand_reg + VALUE_BITS'(1);
                    end
                    else
                    begin
                        div_next = VALUE_BITS'(FIRST_DIVISOR);
                        sq_next  = SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
                    end
                end
            end
            S_CHECK:
            begin
                if (sq_over)
                begin
                    // No divisor up to the square root: the candidate is prime.
                    cnt_next  = cnt_reg + VALUE_BITS'(1);
                    cand_next = cand_reg + VALUE_BITS'(1);
                end
                else
                begin
                    div_req.start = 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.rem_zero)
                    begin
                        cand_next = cand_reg + VALUE_BITS'(1);
                    end
                    else
                    begin
                        // (d+1)^2 = d^2 + 2d + 1
                        sq_next  = sq_reg + {1'b0, div_reg, 1'b0} + SQ_W'(1);
                        div_next = div_reg + VALUE_BITS'(1);
                    end
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cand_reg  <= '0;
            div_reg   <= '0;
            sq_reg    <= '0;
            cnt_reg   <= '0;
            lim_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cand_reg  <= cand_next;
            div_reg   <= div_next;
            sq_reg    <= sq_next;
            cnt_reg   <= cnt_next;
            lim_reg   <= lim_next;
        end
    end

    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = (state_reg == S_DONE);
    assign result    = cnt_reg;

`ifndef SYNTHESIS
    a_square_tracks_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (sq_reg == SQ_W'(div_reg) * SQ_W'(div_reg)))
        else $error("square register does not match the divisor");

    a_candidate_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (cand_reg <= lim_reg))
        else $error("candidate ran past the limit");

    a_done_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside a trial division");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (cnt_reg <= cand_reg))
        else $error("prime count exceeds candidates examined");
`endif

endmodule

`default_nettype wire

// File: src/prime_counter_trial_division_unit.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  go
// out       output     out_valid/out_stall  prime_count
// cfg       input      cfg_wen              cfg_wdata (limit)
//
// A request with go set runs one count; a request with go clear is dropped.
// Each trial division runs in the bit-serial remainder unit, which
// produces one quotient bit a cycle.
// Reset clears the sequencer and the output valid flag and loads the default limit.
// in_stall is high for the whole count; the result then waits in the output
// register while out_stall is high, and a new request may be taken meanwhile.
`default_nettype none

module prime_counter_trial_division_unit #(
    parameter int VALUE_BITS = ptd_pkg::VALUE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  go,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [VALUE_BITS-1:0]      prime_count,
    input  wire logic                  cfg_wen,
    input  wire logic [VALUE_BITS-1:0] cfg_wdata
);
    import ptd_pkg::*;

    logic [VALUE_BITS-1:0] limit_reg, limit_next;
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] prime_count_reg, prime_count_next;

    ctr_stat_t             ctr_stat;
    logic [VALUE_BITS-1:0] ctr_result;
    logic                  ctr_start;
    logic                  out_load;

    assign in_stall  = ctr_stat.busy;
    assign ctr_start = in_valid && !in_stall && go;
    assign out_load  = ctr_stat.done && (!out_valid_reg || !out_stall);

    ptd_counter #(
        .VALUE_BITS(VALUE_BITS)
    ) u_counter (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctr_start),
        .ack   (out_load),
        .limit (limit_reg),
        .stat  (ctr_stat),
        .result(ctr_result)
    );

    always_comb
    begin
        limit_next       = cfg_wen ? cfg_wdata : limit_reg;
        prime_count_next = out_load ? ctr_result : prime_count_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= VALUE_BITS'(LIMIT_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prime_count_reg <= prime_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign prime_count = prime_count_reg;

endmodule

`default_nettype wire

// File: tb/prime_counter_trial_division_unit_test.sv
`timescale 1ns / 1ps

module prime_counter_trial_division_unit_test;

    localparam int COUNT_BITS = ptd_pkg::VALUE_BITS_DEF;
    localparam int IDLE_PCT = 18;
    localparam int REQUEST_COUNT = 100;
    localparam int SETTLE_CYCLES = 50;
    localparam longint CYCLE_LIMIT = 20_000_000;

    typedef logic [COUNT_BITS-1:0] count_t;

    // Keeps its own copy of the limit register and the queue of prime counts
    // that the accepted requests still owe.
    class prime_tally_board;
        count_t limit_copy;
        count_t expected_counts[$];
        int errors;

        function new();
            limit_copy = count_t'(ptd_pkg::LIMIT_RESET);
            errors = 0;
        endfunction

        function count_t primes_below(count_t bound);
            longint unsigned n;
            longint unsigned d;
            count_t tally;
            bit no_factor;
            tally = '0;
            for (n = 2; n < bound; n++)
            begin
                no_factor = 1'b1;
                for (d = 2; d * d <= n; d++)
                begin
                    if (n % d == 0)
                    begin
                        no_factor = 1'b0;
                        break;
                    end
                end
                if (no_factor)
                    tally++;
            end
            return tally;
        endfunction

        function void set_limit(count_t value);
            limit_copy = value;
        endfunction

        function void note_request(logic start);
            if (start)
                expected_counts.push_back(primes_below(limit_copy));
        endfunction

        function void check_count(count_t actual);
            count_t expected;
            if (expected_counts.size() == 0)
            begin
                $error("prime_count: no count expected, actual %0d", actual);
                errors++;
            end
            else
            begin
                expected = expected_counts.pop_front();
                if (actual !== expected)
                begin
                    $error("prime_count: expected %0d, actual %0d", expected, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_counts.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic go;
    logic out_valid;
    logic out_stall;
    count_t prime_count;
    logic cfg_wen;
    count_t cfg_wdata;

    logic calm;
    longint cycles;
    int requests_sent;

    prime_tally_board board = new();

    prime_counter_trial_division_unit #(
        .VALUE_BITS(COUNT_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .go(go),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .prime_count(prime_count),
        .cfg_wen(cfg_wen),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        if (rst_n && out_valid && !out_stall)
            board.check_count(prime_count);
    end

    // The request stays up until an edge where the block does not stall it.
    task automatic send_request(input logic start);
        while (!calm && ($urandom_range(99) < IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        go <= start;
        do
            @(posedge clk);
        while (in_stall);
        board.note_request(start);
        requests_sent++;
    endtask

    // Holds off until every owed count has come back, then lets the clock run
    // on with no request up.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(input count_t value);
        drain();
        cfg_wen <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        board.set_limit(value);
    endtask

    task automatic count_with_limit(input count_t value);
        write_limit(value);
        send_request(1'b1);
    endtask

    initial
    begin
        int batch;
        int i;
        count_t value;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        go <= 1'b0;
        cfg_wen <= 1'b0;
        cfg_wdata <= '0;
        calm = 1'b0;
        cycles = 0;
        requests_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Small limits, dropped requests, and a few squares and primes at the bound.
        count_with_limit('0);
        send_request(1'b0);
        count_with_limit(count_t'(1));
        count_with_limit(count_t'(2));
        send_request(1'b0);
        send_request(1'b1);
        count_with_limit(count_t'(3));
        count_with_limit(count_t'(4));
        count_with_limit(count_t'(5));
        count_with_limit(count_t'(10));
        count_with_limit(count_t'(11));
        count_with_limit(count_t'(25));
        count_with_limit(count_t'(49));
        send_request(1'b1);
        count_with_limit(count_t'(100));

        // Wide register patterns are loaded but never counted; they would run for ages.
        write_limit('1);
        write_limit(count_t'(32'h2AAA_AAAA));
        write_limit(count_t'(32'h5555_5555));
        count_with_limit(count_t'(1000));
        count_with_limit(count_t'(7));

        while (requests_sent < REQUEST_COUNT)
        begin
            calm = (requests_sent >= 40) && (requests_sent < 65);
            if ($urandom_range(9) == 0)
                value = count_t'($urandom_range(200, 41));
            else
                value = count_t'($urandom_range(40));
            write_limit(value);
            batch = $urandom_range(4, 1);
            for (i = 0; i < batch; i++)
                send_request($urandom_range(99) < 80);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
src/ptd_pkg.sv
src/ptd_divider.sv
src/ptd_counter.sv
src/prime_counter_trial_division_unit.sv
tb/prime_counter_trial_division_unit_test.sv
